[design/modular_exponentiation_core_defines.svh]
// Assertion macros for the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MEC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MEC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/mexp_pkg.sv]
package mexp_pkg;
    localparam int EXP_WIDTH_DEF = 63;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int RES_WIDTH     = 64;
    localparam int BASE_WIDTH    = 32;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
    localparam logic [0:0] REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        t_IDLE     = 3'd0,
        t_LOAD     = 3'd1,
        t_MUL      = 3'd2,
        t_RED      = 3'd3,
        t_NEXT     = 3'd4,
        t_OUT      = 3'd5,
        t_CROSS_LO = 3'd6,
        t_CROSS_HI = 3'd7
    } t_state;

    typedef enum logic [1:0] {
        t_OP_INIT = 2'd0,
        t_OP_ACC  = 2'd1,
        t_OP_SQ   = 2'd2
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic mul_start; // form low product of selected operands
        logic cross_lo;  // add low operand a times high operand b into upper half
        logic cross_hi;  // add high operand a times low operand b, write back
        t_op  op;        // which value the reduction writes back
        logic red_step;  // one restoring-division bit step
        logic shift_exp; // drop one exponent bit
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic exp_bit;   // current exponent bit
        logic mod_zero;  // no reduction
        logic red_last;  // last reduction step
    } t_status;
endpackage

[design/mexp_datapath.sv]
module mexp_datapath #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mexp_pkg::t_cmd                i_cmd,
    output mexp_pkg::t_status             o_status,
    input  logic [MOD_WIDTH-1:0]          i_modulus,
    input  logic [mexp_pkg::BASE_WIDTH-1:0] i_base,
    input  logic [EXP_WIDTH-1:0]          i_exponent,
    output logic [mexp_pkg::RES_WIDTH-1:0] o_result
);
    import mexp_pkg::*;
    localparam int CW   = $clog2(RES_WIDTH);
    localparam int HALF = RES_WIDTH / 2;

    logic [RES_WIDTH-1:0] r_acc, n_acc, r_sq, n_sq;
    logic [RES_WIDTH-1:0] r_prod, n_prod;
    logic [MOD_WIDTH-1:0] r_rem, n_rem;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [EXP_WIDTH-1:0] r_exp;
    logic [CW-1:0]        r_cnt;
    logic [MOD_WIDTH:0]   w_trial;
    logic [RES_WIDTH-1:0] w_a, w_b;
    logic [HALF-1:0]      w_mx, w_my;
    logic [RES_WIDTH-1:0] w_mul;

    // remainder step: shift in one product bit, subtract if it fits
    assign w_trial = {r_rem, r_prod[RES_WIDTH-1]} - {1'b0, r_mod};

    // square the running square, or multiply it into the accumulator
    assign w_a = (i_cmd.op == t_OP_SQ) ? r_sq : r_acc;
    assign w_b = r_sq;

    // share one half-width multiplier between the low product and the cross terms
    always_comb begin
        w_mx = w_a[HALF-1:0];
        w_my = w_b[HALF-1:0];
        if (i_cmd.cross_lo) w_my = w_b[RES_WIDTH-1:HALF];
        if (i_cmd.cross_hi) w_mx = w_a[RES_WIDTH-1:HALF];
    end
    assign w_mul = {{HALF{1'b0}}, w_mx} * {{HALF{1'b0}}, w_my};

    always_comb begin
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_prod = r_prod;
        n_rem  = r_rem;
        if (i_cmd.load) begin
            n_acc  = RES_WIDTH'(1);
            n_sq   = RES_WIDTH'(i_base);
            n_prod = '0;
            n_rem  = '0;
        end else if (i_cmd.mul_start) begin
            // reduce the base itself first, products afterwards
            n_prod = (i_cmd.op == t_OP_INIT) ? r_sq : w_mul;
            n_rem  = '0;
        end else if (i_cmd.cross_lo || i_cmd.cross_hi) begin
            // wrap at 64 bits: only the low half of each cross term counts
            n_prod = {r_prod[RES_WIDTH-1:HALF] + w_mul[HALF-1:0], r_prod[HALF-1:0]};
            if (i_cmd.cross_hi) begin
                if (i_cmd.op == t_OP_ACC) n_acc = n_prod;
                if (i_cmd.op == t_OP_SQ)  n_sq = n_prod;
            end
        end else if (i_cmd.red_step) begin
            n_prod = {r_prod[RES_WIDTH-2:0], 1'b0};
            if (!w_trial[MOD_WIDTH]) begin
                n_rem = w_trial[MOD_WIDTH-1:0];
            end else begin
                n_rem = {r_rem[MOD_WIDTH-2:0], r_prod[RES_WIDTH-1]};
            end
            // write back the finished remainder
            if (r_cnt == CW'(RES_WIDTH-1)) begin
                unique case (i_cmd.op)
                    t_OP_INIT: begin
                        // accumulator starts at 1 mod m, which is 0 for a modulus of one
                        n_sq  = RES_WIDTH'(n_rem);
                        n_acc = RES_WIDTH'(r_mod != MOD_WIDTH'(1));
                    end
                    t_OP_ACC: n_acc = RES_WIDTH'(n_rem);
                    t_OP_SQ:  n_sq = RES_WIDTH'(n_rem);
                    default:  n_acc = r_acc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_cnt <= '0;
        end else if (i_cmd.red_step) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.load) begin
            r_mod <= i_modulus;
            r_exp <= i_exponent;
        end else if (i_cmd.shift_exp) begin
            r_exp <= r_exp >> 1;
        end
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_prod <= n_prod;
        r_rem  <= n_rem;
    end

    assign o_status.exp_bit  = r_exp[0];
    assign o_status.mod_zero = (r_mod == '0);
    assign o_status.red_last = (r_cnt == CW'(RES_WIDTH-1));
    assign o_result = r_acc;
endmodule

[design/mexp_ctrl.sv]
`include "modular_exponentiation_core_defines.svh"
module mexp_ctrl #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  mexp_pkg::t_status i_status,
    output mexp_pkg::t_cmd    o_cmd
);
    import mexp_pkg::*;
    localparam int BW = $clog2(EXP_WIDTH + 1);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [BW-1:0] r_bit, n_bit;

    // next state
    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_bit = r_bit;
        unique case (r_state)
            t_IDLE: if (i_valid) n_state = t_LOAD;
            t_LOAD: begin
                n_op = t_OP_INIT;
                n_bit = '0;
                n_state = t_MUL;
            end
            t_MUL: n_state = i_status.mod_zero ? t_CROSS_LO : t_RED;
            t_CROSS_LO: n_state = t_CROSS_HI;
            t_CROSS_HI: n_state = t_NEXT;
            t_RED: if (i_status.red_last) n_state = t_NEXT;
            t_NEXT: begin
                priority if (r_op == t_OP_INIT) begin
                    n_op = i_status.exp_bit ? t_OP_ACC : t_OP_SQ;
                    n_state = t_MUL;
                    if (EXP_WIDTH == 0) n_state = t_OUT;
                end else if (r_op == t_OP_ACC) begin
                    n_op = t_OP_SQ;
                    n_state = t_MUL;
                end else begin
                    n_bit = r_bit + BW'(1);
                    if (r_bit == BW'(EXP_WIDTH - 1)) begin
                        n_state = t_OUT;
                    end else begin
                        n_op = i_status.exp_bit ? t_OP_ACC : t_OP_SQ;
                        n_state = t_MUL;
                    end
                end
            end
            t_OUT: if (!i_stall) n_state = t_IDLE;
            default: n_state = t_IDLE;
        endcase
    end

    // outputs: capture operands on the accepting edge, drop an exponent bit once it is used
    always_comb begin
        o_cmd = '0;
        o_cmd.op = r_op;
        o_stall = (r_state != t_IDLE);
        o_valid = (r_state == t_OUT);
        unique case (r_state)
            t_IDLE:     o_cmd.load = i_valid;
            t_MUL:      o_cmd.mul_start = 1'b1;
            t_CROSS_LO: o_cmd.cross_lo = 1'b1;
            t_CROSS_HI: o_cmd.cross_hi = 1'b1;
            t_RED:      o_cmd.red_step = 1'b1;
            t_NEXT:     o_cmd.shift_exp = (r_op != t_OP_ACC);
            default:    o_cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_op <= t_OP_INIT;
            r_bit <= '0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_bit <= n_bit;
        end
    end

    `MEC_ASSERT_IMP(a_out_valid, i_clk, i_rst_n, o_valid, o_stall)
    `MEC_ASSERT_NXT(a_accept_load, i_clk, i_rst_n, i_valid && !o_stall, r_state == t_LOAD)
    `MEC_ASSERT_IMP(a_red_only_mod, i_clk, i_rst_n, r_state == t_RED, !i_status.mod_zero)
    `MEC_ASSERT_IMP(a_cross_no_mod, i_clk, i_rst_n, r_state == t_CROSS_LO, i_status.mod_zero)
    `MEC_ASSERT_IMP(a_bit_range, i_clk, i_rst_n, r_state == t_NEXT, r_bit < BW'(EXP_WIDTH))
endmodule

[design/modular_exponentiation_core.sv]
// Modular exponentiation core: base^exponent by square-and-multiply.
// With a nonzero modulus each product is reduced by the one-bit-per-cycle remainder unit.
// With a zero modulus no reduction is done and products wrap at 64 bits.
// One item at a time; the next word is taken in the cycle after the result leaves.
// Synchronous active-low reset idles the controller; modulus resets to 1000000007.
module modular_exponentiation_core #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_base,
    input  logic [EXP_WIDTH-1:0] i_exponent,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mexp_pkg::*;

    logic [MOD_WIDTH-1:0] r_modulus;
    t_cmd    w_cmd;
    t_status w_status;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET[MOD_WIDTH-1:0];
        end else if (psel && penable && pwrite && paddr[1:0] == {REG_MODULUS, 1'b0}) begin
            r_modulus <= pwdata[MOD_WIDTH-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == {REG_MODULUS, 1'b0}) ? 32'(r_modulus) : '0;

    mexp_ctrl #(.EXP_WIDTH(EXP_WIDTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    mexp_datapath #(.EXP_WIDTH(EXP_WIDTH), .MOD_WIDTH(MOD_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_modulus(r_modulus), .i_base, .i_exponent, .o_result
    );
endmodule
